FILE: src/asi_pkg.sv
// asi_pkg: shared types, reset values and constants for adaptive_sleep_interval.
// No dependencies; imported by every module of the block.
`default_nettype none

package asi_pkg;

	localparam int VOLT_W     = 13;
	localparam int SEC_W      = 20;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int HIST_N_W   = 4;

	localparam int HISTORY_DEPTH_DEF = 4;

	localparam logic [SEC_W-1:0] MAX_INTERVAL     = 20'd172800;
	localparam logic [SEC_W-1:0] DEFAULT_INTERVAL = 20'd3600;

	// floor(y/5) = (y * DIV5_RECIP) >> DIV5_SHIFT for any y below 2**22
	localparam logic [21:0] DIV5_RECIP = 22'd3355444;
	localparam int          DIV5_SHIFT = 24;

	localparam logic [VOLT_W-1:0] CRITICAL_MV_RST  = 13'd3300;
	localparam logic [VOLT_W-1:0] LOW_MV_RST       = 13'd3500;
	localparam logic [VOLT_W-1:0] MEDIUM_MV_RST    = 13'd3700;
	localparam logic [THR_W-1:0]  CHARGE_THR_RST   = 8'd5;
	localparam logic [SEC_W-1:0]  EMERGENCY_S_RST  = 20'd86400;
	localparam logic [SEC_W-1:0]  LOW_BAND_S_RST   = 20'd28800;
	localparam logic [SEC_W-1:0]  MEDIUM_BAND_S_RST = 20'd14400;
	localparam logic [SEC_W-1:0]  FLOOR_S_RST      = 20'd3600;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CRITICAL_MV    = 3'd0,
		CFG_LOW_MV         = 3'd1,
		CFG_MEDIUM_MV      = 3'd2,
		CFG_CHARGE_THR_MV  = 3'd3,
		CFG_EMERGENCY_S    = 3'd4,
		CFG_LOW_BAND_S     = 3'd5,
		CFG_MEDIUM_BAND_S  = 3'd6,
		CFG_FLOOR_S        = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PS_STABLE     = 3'd0,
		PS_CHARGING   = 3'd1,
		PS_DRAINING   = 3'd2,
		PS_DRAIN_FAST = 3'd3,
		PS_EMERGENCY  = 3'd4
	} power_state_t;

	typedef struct packed {
		logic [VOLT_W-1:0] critical_mv;
		logic [VOLT_W-1:0] low_mv;
		logic [VOLT_W-1:0] medium_mv;
		logic [THR_W-1:0]  charge_threshold_mv;
		logic [SEC_W-1:0]  emergency_seconds;
		logic [SEC_W-1:0]  low_band_seconds;
		logic [SEC_W-1:0]  medium_band_seconds;
		logic [SEC_W-1:0]  floor_seconds;
	} cfg_t;

	// history view for the word in flight: trend usable, span and oldest sample
	typedef struct packed {
		logic                trend_ok;
		logic [HIST_N_W-1:0] span;
		logic [VOLT_W-1:0]   oldest;
	} hist_t;

endpackage

`default_nettype wire

FILE: src/asi_cfg_regs.sv
// asi_cfg_regs: the eight configuration registers and their write port.
// Depends on asi_pkg.
`default_nettype none

module asi_cfg_regs import asi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_mv         <= CRITICAL_MV_RST;
			cfg_q.low_mv              <= LOW_MV_RST;
			cfg_q.medium_mv           <= MEDIUM_MV_RST;
			cfg_q.charge_threshold_mv <= CHARGE_THR_RST;
			cfg_q.emergency_seconds   <= EMERGENCY_S_RST;
			cfg_q.low_band_seconds    <= LOW_BAND_S_RST;
			cfg_q.medium_band_seconds <= MEDIUM_BAND_S_RST;
			cfg_q.floor_seconds       <= FLOOR_S_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_CRITICAL_MV:   cfg_q.critical_mv         <= wr_data[VOLT_W-1:0];
				CFG_LOW_MV:        cfg_q.low_mv              <= wr_data[VOLT_W-1:0];
				CFG_MEDIUM_MV:     cfg_q.medium_mv           <= wr_data[VOLT_W-1:0];
				CFG_CHARGE_THR_MV: cfg_q.charge_threshold_mv <= wr_data[THR_W-1:0];
				CFG_EMERGENCY_S:   cfg_q.emergency_seconds   <= wr_data[SEC_W-1:0];
				CFG_LOW_BAND_S:    cfg_q.low_band_seconds    <= wr_data[SEC_W-1:0];
				CFG_MEDIUM_BAND_S: cfg_q.medium_band_seconds <= wr_data[SEC_W-1:0];
				CFG_FLOOR_S:       cfg_q.floor_seconds       <= wr_data[SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/asi_history.sv
// asi_history: voltage ring with write slot and fill count; presents the oldest
// sample and the trend span for the word in flight. Depends on asi_pkg.
`default_nettype none

module asi_history import asi_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [VOLT_W-1:0] voltage,
	output hist_t                  hist
);

	localparam int SW = $clog2(HISTORY_DEPTH);
	localparam int FW = $clog2(HISTORY_DEPTH + 1);

	logic [VOLT_W-1:0] ring_q [HISTORY_DEPTH];
	logic [SW-1:0]     slot_q;
	logic [FW-1:0]     fill_q;
	logic [SW-1:0]     slot_next;
	logic              full;

	assign full      = (fill_q == FW'(HISTORY_DEPTH));
	assign slot_next = (slot_q == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SW'(1);

	always_ff @(posedge clk) begin
		if (push) begin
			ring_q[slot_q] <= voltage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			slot_q <= slot_next;
			if (!full) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// before the ring wraps the oldest sample sits in slot 0
	always_comb begin
		hist.trend_ok = (fill_q != '0);
		hist.span     = full ? HIST_N_W'(HISTORY_DEPTH - 1) : HIST_N_W'(fill_q);
		hist.oldest   = full ? ring_q[slot_next] : ring_q[0];
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HISTORY_DEPTH))
		else $error("fill count beyond history depth");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (FW'(slot_q) == fill_q))
		else $error("write slot out of step with fill count");

endmodule

`default_nettype wire

FILE: src/asi_decide.sv
// asi_decide: trend classification, interval scaling, band and maximum clamping and critical override for one word.
// Depends on asi_pkg.
`default_nettype none

module asi_decide import asi_pkg::*; (
	input  wire logic              [VOLT_W-1:0] voltage,
	input  wire hist_t                          hist,
	input  wire cfg_t                           cfg,
	input  wire logic              [SEC_W-1:0]  interval,
	output logic                   [SEC_W-1:0]  sleep_next,
	output power_state_t                        state_next
);

	logic signed [15:0] diff;
	logic signed [15:0] neg_diff;
	logic        [11:0] chg_lim;
	logic signed [15:0] chg_lim_s;
	logic signed [15:0] span_s;
	logic signed [15:0] fast_lim;
	logic signed [15:0] med_lim;
	logic        [21:0] x4;
	logic        [43:0] div5_prod;
	logic        [SEC_W:0] nx;
	logic        [SEC_W:0] clamped;
	logic        [SEC_W-1:0] band_min;

	assign diff      = $signed({3'b000, voltage}) - $signed({3'b000, hist.oldest});
	assign neg_diff  = -diff;
	assign chg_lim   = {4'd0, cfg.charge_threshold_mv} * {8'd0, hist.span};
	assign chg_lim_s = $signed({4'b0000, chg_lim});
	assign span_s    = $signed({12'd0, hist.span});
	assign fast_lim  = span_s * 16'sd20;
	assign med_lim   = span_s * 16'sd10;

	assign x4        = {interval, 2'b00};
	assign div5_prod = {22'd0, x4} * {22'd0, DIV5_RECIP};

	always_comb begin
		if (voltage < cfg.low_mv) begin
			band_min = cfg.low_band_seconds;
		end else if (voltage < cfg.medium_mv) begin
			band_min = cfg.medium_band_seconds;
		end else begin
			band_min = cfg.floor_seconds;
		end
	end

	always_comb begin
		state_next = PS_STABLE;
		nx         = {1'b0, interval};
		if (hist.trend_ok) begin
			if (diff > chg_lim_s) begin
				state_next = PS_CHARGING;
				nx         = {1'b0, div5_prod[DIV5_SHIFT+SEC_W-1:DIV5_SHIFT]};
			end else if (diff < -span_s) begin
				if (neg_diff > fast_lim) begin
					state_next = PS_DRAIN_FAST;
					nx         = {interval, 1'b0};
				end else if (neg_diff > med_lim) begin
					state_next = PS_DRAINING;
					nx         = 21'(({2'b00, interval} * 22'd3) >> 1);
				end else begin
					state_next = PS_DRAINING;
					nx         = 21'(({3'b000, interval} * 23'd5) >> 2);
				end
			end
		end

		clamped = (nx < {1'b0, band_min}) ? {1'b0, band_min} : nx;
		if (clamped > {1'b0, MAX_INTERVAL}) begin
			clamped = {1'b0, MAX_INTERVAL};
		end
		sleep_next = clamped[SEC_W-1:0];

		if (voltage < cfg.critical_mv) begin
			state_next = PS_EMERGENCY;
			sleep_next = cfg.emergency_seconds;
		end
	end

endmodule

`default_nettype wire

FILE: src/adaptive_sleep_interval.sv
// adaptive_sleep_interval: top level; input register, decision logic, result register.
// Depends on asi_pkg, asi_cfg_regs, asi_history, asi_decide.
//
//  channel  handshake            payload
//  in       in_valid / in_stall   voltage_mv
//  out      out_valid / out_stall sleep_seconds, power_state
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while the result is not stalled.
// The interval and history feedback closes in the stage between the input
// register and the result register, so back-to-back words see fresh state.
// Reset clears handshake state and history counters and loads DEFAULT_INTERVAL.
// A stalled result holds; one more word waits in the input register.
`default_nettype none

module adaptive_sleep_interval import asi_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VOLT_W-1:0]     voltage_mv,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [SEC_W-1:0]           sleep_seconds,
	output logic [2:0]                 power_state,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg;
	hist_t             hist;
	logic              valid_s1;
	logic [VOLT_W-1:0] voltage_s1;
	logic              advance;
	logic              accept;
	logic [SEC_W-1:0]  interval_q;
	logic [SEC_W-1:0]  sleep_next;
	power_state_t      state_next;
	logic              out_valid_q;
	logic [SEC_W-1:0]  sleep_q;
	power_state_t      state_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	asi_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	asi_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance),
		.voltage (voltage_s1),
		.hist    (hist)
	);

	asi_decide u_decide (
		.voltage    (voltage_s1),
		.hist       (hist),
		.cfg        (cfg),
		.interval   (interval_q),
		.sleep_next (sleep_next),
		.state_next (state_next)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			voltage_s1 <= voltage_mv;
		end
		if (advance) begin
			sleep_q <= sleep_next;
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			interval_q  <= DEFAULT_INTERVAL;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				interval_q  <= sleep_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sleep_seconds = sleep_q;
	assign power_state   = state_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_max_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (power_state != PS_EMERGENCY)) |-> (sleep_seconds <= MAX_INTERVAL))
		else $error("interval above maximum outside emergency");

	a_interval_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (interval_q == sleep_q))
		else $error("current interval differs from last result");

endmodule

`default_nettype wire
